// ===== rtl/plist_pkg.sv =====
// Shared constants, codes and types for the packed list block.
package plist_pkg;

  localparam int DEPTH  = 128;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 7;
  localparam int COUNT_W  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VALUE_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== rtl/plist_if.sv =====
// Request and response channel interfaces of the packed list block.
interface plist_req_if import plist_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink (input valid, input operation, input value, input position,
                output ready);
endinterface

interface plist_rsp_if import plist_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  found_index;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output status, output found_index, output count,
                  input ready);
  modport sink (input valid, input status, input found_index, input count,
                output ready);
endinterface

// ===== rtl/plist_mem.sv =====
// Entry store: one write port, one read port with registered read data.
module plist_mem import plist_pkg::*; (
  input  logic               clk,
  input  mem_req_t           req,
  output logic [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== rtl/plist_ctrl.sv =====
// Operation sequencer: append, shift-down delete, linear search, result register.
module plist_ctrl import plist_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  plist_req_if.sink          req,
  plist_rsp_if.source        rsp,
  output mem_req_t           mem_req,
  input  logic [VALUE_W-1:0] rdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    elem_count;
  logic [CNT_W-1:0]    rd_ptr;
  logic [ADDR_W-1:0]   wr_ptr;
  logic                pend;
  logic [VALUE_W-1:0]  key;
  status_t             res_status;
  logic [INDEX_W-1:0]  res_index;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [INDEX_W-1:0]  out_index;
  logic [COUNT_W-1:0]  out_count;

  logic accept;
  logic full;
  logic issue;
  logic out_free;

  assign req.ready       = (state == S_IDLE);
  assign accept          = req.valid && req.ready;
  assign full            = (elem_count == CNT_W'(DEPTH));
  assign issue           = (rd_ptr < elem_count);
  assign out_free        = !out_valid || rsp.ready;
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found_index = out_index;
  assign rsp.count       = out_count;

  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.waddr = wr_ptr;
    mem_req.wdata = rdata;
    mem_req.raddr = rd_ptr[ADDR_W-1:0];
    if (state == S_IDLE && accept && op_t'(req.operation) == OP_APPEND && !full) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = elem_count[ADDR_W-1:0];
      mem_req.wdata = req.value;
    end else if (state == S_SHIFT && pend) begin
      // move the entry read last cycle one place down
      mem_req.we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      elem_count <= '0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // the result load below takes over out_valid while emitting
      if (out_valid && rsp.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key       <= req.value;
            res_index <= '0;
            pend      <= 1'b0;
            case (op_t'(req.operation))
              OP_APPEND: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  elem_count <= elem_count + CNT_W'(1);
                  res_status <= ST_OK;
                end
                state <= S_EMIT;
              end
              OP_DELETE: begin
                if (32'(req.position) >= 32'(elem_count)) begin
                  res_status <= ST_RANGE;
                  state      <= S_EMIT;
                end else begin
                  wr_ptr <= ADDR_W'(req.position);
                  rd_ptr <= CNT_W'(req.position) + CNT_W'(1);
                  state  <= S_SHIFT;
                end
              end
              OP_SEARCH: begin
                rd_ptr <= '0;
                state  <= S_SCAN;
              end
              default: begin
                res_status <= ST_OK;
                state      <= S_EMIT;
              end
            endcase
          end
        end
        S_SHIFT: begin
          pend <= issue;
          if (issue) begin
            rd_ptr <= rd_ptr + CNT_W'(1);
          end
          if (pend) begin
            wr_ptr <= wr_ptr + ADDR_W'(1);
          end
          if (!pend && !issue) begin
            elem_count <= elem_count - CNT_W'(1);
            res_status <= ST_OK;
            state      <= S_EMIT;
          end
        end
        S_SCAN: begin
          if (pend && rdata == key) begin
            // data in hand came from the address issued last cycle
            res_status <= ST_OK;
            res_index  <= INDEX_W'(rd_ptr - CNT_W'(1));
            pend       <= 1'b0;
            state      <= S_EMIT;
          end else if (issue) begin
            rd_ptr <= rd_ptr + CNT_W'(1);
            pend   <= 1'b1;
          end else begin
            res_status <= ST_NOTFOUND;
            pend       <= 1'b0;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_index  <= res_index;
            out_count  <= COUNT_W'(elem_count);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/packed_list_append_delete_search.sv =====
// Packed list top level: sequencer plus entry store.
//
//  channel  direction  payload
//  req      in         operation, value, position
//  rsp      out        status, found_index, count
//
// Append and unused codes go from accept through S_EMIT to the result register.
// Delete at position p moves every later entry one place down, one entry moved
// per cycle through the store's one read port and one write port. Search compares
// one entry per cycle and stops at the first hit. One item is worked at a time;
// req is ready again once its result is loaded, even if rsp is still stalled.
// Synchronous reset empties the list; the store itself is not cleared.
module packed_list_append_delete_search import plist_pkg::*; (
  input logic         clk,
  input logic         rst,
  plist_req_if.sink   req,
  plist_rsp_if.source rsp
);

  mem_req_t           mem_req;
  logic [VALUE_W-1:0] rdata;

  plist_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  plist_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the packed list block: random ops, predicted results, stalls.
module testbench;
  import plist_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } list_item_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  found_index;
    logic [COUNT_W-1:0]  count;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  plist_req_if req_ch ();
  plist_rsp_if rsp_ch ();

  packed_list_append_delete_search u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  list_item_t item_q [$];
  list_rsp_t  pending_results [$];

  // Shadow of the list contents
  logic [VALUE_W-1:0] list_entries [DEPTH];
  int                 list_count = 0;

  int error_count = 0;
  int cycle_count = 0;
  int gen_count   = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int rx_mode     = 0;
  int mode_left   = 0;
  int stall_left  = 0;

  logic signed [VALUE_W-1:0] value_pool [12] = '{
    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, -32'sd1,
    32'sd1, 32'sd42, -32'sd42, 32'sh5555_5555,
    32'shAAAA_AAAA, 32'sh0001_0000, 32'sh7FFF_0000, 32'sh8000_0001
  };

  // Apply one operation to the shadow list and return the result it gives.
  function automatic list_rsp_t list_apply(input list_item_t it);
    list_rsp_t r;
    int        hit;
    r.status      = ST_OK;
    r.found_index = '0;
    hit           = -1;
    case (it.op)
      OP_APPEND: begin
        if (list_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_entries[list_count] = it.value;
          list_count++;
        end
      end
      OP_DELETE: begin
        if (int'(it.position) >= list_count) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = int'(it.position); i + 1 < list_count; i++)
            list_entries[i] = list_entries[i + 1];
          list_count--;
        end
      end
      OP_SEARCH: begin
        for (int i = 0; i < list_count; i++)
          if (hit < 0 && list_entries[i] == it.value) hit = i;
        if (hit < 0) r.status = ST_NOTFOUND;
        else r.found_index = hit[INDEX_W-1:0];
      end
      default: ;
    endcase
    r.count = list_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic void queue_item(input logic [OP_W-1:0] op,
                                     input logic signed [VALUE_W-1:0] value,
                                     input logic [POS_W-1:0] position);
    list_item_t it;
    it.op       = op;
    it.value    = value;
    it.position = position;
    item_q.push_back(it);
    // track the fill level so delete positions can aim inside the list
    if (op == OP_APPEND && gen_count < DEPTH) gen_count++;
    if (op == OP_DELETE && int'(position) < gen_count) gen_count--;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 60) return value_pool[$urandom_range(0, 11)];
    return $urandom;
  endfunction

  // Sender: bursts of items with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        pending_results.push_back(list_apply(item_q.pop_front()));
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (item_q.size() > 0) begin
          req_ch.operation <= item_q[0].op;
          req_ch.value     <= item_q[0].value;
          req_ch.position  <= item_q[0].position;
          req_ch.valid     <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result, stall on a shifting pattern
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("unexpected result: status=%0d index=%0d count=%0d",
                     rsp_ch.status, rsp_ch.found_index, rsp_ch.count);
        end else begin
          list_rsp_t want;
          want = pending_results.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.found_index !== want.found_index ||
              rsp_ch.count !== want.count) begin
            error_count++;
            if (error_count <= REPORT_MAX)
              $display("mismatch: expected status=%0d index=%0d count=%0d, got %0d %0d %0d",
                       want.status, want.found_index, want.count,
                       rsp_ch.status, rsp_ch.found_index, rsp_ch.count);
          end
        end
      end
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
          end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 20);
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("packed_list_append_delete_search verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int app_pct [4];
    int del_pct [4];
    int issued;
    int phase;
    int plen;
    int roll;
    logic [POS_W-1:0] pos;

    app_pct = '{85, 45, 10, 40};
    del_pct = '{5, 25, 75, 30};

    req_ch.valid     = 1'b0;
    req_ch.operation = '0;
    req_ch.value     = '0;
    req_ch.position  = '0;
    rsp_ch.ready     = 1'b0;

    // empty list: search misses, deletes are out of range, unused code is ignored
    queue_item(OP_SEARCH, 32'sd0, 7'd0);
    queue_item(OP_DELETE, 32'sd0, 7'd0);
    queue_item(OP_DELETE, -32'sd1, 7'd127);
    queue_item(OP_UNUSED, 32'sd0, 7'd0);
    queue_item(OP_APPEND, 32'sh8000_0000, 7'd0);
    queue_item(OP_APPEND, 32'sh7FFF_FFFF, 7'd127);
    queue_item(OP_APPEND, 32'sd0, 7'd0);
    queue_item(OP_APPEND, -32'sd1, 7'd0);
    queue_item(OP_APPEND, 32'sh7FFF_FFFF, 7'd0);
    // duplicate value: first index wins
    queue_item(OP_SEARCH, 32'sh7FFF_FFFF, 7'd0);
    queue_item(OP_SEARCH, -32'sd1, 7'd127);
    queue_item(OP_SEARCH, 32'sh8000_0000, 7'd0);
    queue_item(OP_SEARCH, 32'sd12345, 7'd0);
    // delete last entry, then at the count and far beyond it
    queue_item(OP_DELETE, 32'sd0, 7'd4);
    queue_item(OP_DELETE, 32'sd0, 7'd4);
    queue_item(OP_DELETE, 32'sd0, 7'd127);
    queue_item(OP_DELETE, 32'sh7FFF_FFFF, 7'd1);
    queue_item(OP_SEARCH, 32'sh7FFF_FFFF, 7'd0);
    queue_item(OP_DELETE, 32'sd0, 7'd0);
    queue_item(OP_UNUSED, -32'sd1, 7'd127);
    queue_item(OP_SEARCH, 32'sd0, 7'd0);
    queue_item(OP_SEARCH, -32'sd1, 7'd0);

    // phases rotate fill, mix, drain, mix so the list reaches full and empty
    issued = 0;
    phase  = 0;
    while (issued < RANDOM_ITEMS) begin
      plen = $urandom_range(120, 220);
      for (int k = 0; k < plen && issued < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < app_pct[phase % 4]) begin
          queue_item(OP_APPEND, pick_value(), 7'($urandom));
          issued++;
        end else if (roll < app_pct[phase % 4] + del_pct[phase % 4]) begin
          if (gen_count > 0 && $urandom_range(0, 99) < 85)
            pos = 7'($urandom_range(0, gen_count - 1));
          else
            pos = 7'($urandom);
          queue_item(OP_DELETE, $urandom, pos);
          issued++;
        end else if (roll < 98) begin
          queue_item(OP_SEARCH, pick_value(), 7'($urandom));
          issued++;
        end else begin
          queue_item(OP_UNUSED, $urandom, 7'($urandom));
        end
      end
      phase++;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (item_q.size() != 0 || req_ch.valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (pending_results.size() != 0) error_count++;
    if (error_count == 0)
      $display("packed_list_append_delete_search verification clean");
    else
      $display("packed_list_append_delete_search verification failed");
    $finish;
  end

endmodule
